// ===== rtl/core/dgrt_pkg.sv =====
`default_nettype none

package dgrt_pkg;

    localparam int unsigned MAX_VERTICES_DEF = 64;
    localparam int unsigned MAX_DEGREE_DEF   = 16;

    localparam int KIND_W   = 2;
    localparam int VTX_W    = 6;
    localparam int COST_W   = 32;
    localparam int STATUS_W = 3;
    localparam int DEG_W    = 5;
    localparam int VTOT_W   = 7;
    localparam int ETOT_W   = 11;
    localparam int CFG_W    = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD_EDGE   = 2'd0,
        KIND_DEL_EDGE   = 2'd1,
        KIND_ADD_VERTEX = 2'd2,
        KIND_CHECK      = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK          = 3'd0,
        STAT_RANGE       = 3'd1,
        STAT_NOT_FOUND   = 3'd2,
        STAT_DEGREE_FULL = 3'd3,
        STAT_TABLE_FULL  = 3'd4
    } status_t;

    typedef struct packed {
        kind_t                     kind;
        logic [VTX_W-1:0]          from_vertex;
        logic [VTX_W-1:0]          to_vertex;
        logic signed [COST_W-1:0]  edge_cost;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic [DEG_W-1:0]          out_degree;
        logic [VTOT_W-1:0]         vertex_total;
        logic [ETOT_W-1:0]         edge_total;
        logic                      all_reached;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/dgrt_req_if.sv =====
`default_nettype none

interface dgrt_req_if import dgrt_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dgrt_rsp_if.sv =====
`default_nettype none

interface dgrt_rsp_if import dgrt_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/directed_graph_reachability_table.sv =====
// Directed graph table with bounded adjacency lists and a connectivity check.
// The req channel carries one request item: kind, from_vertex, to_vertex and
// edge_cost. The rsp channel returns exactly one result item per request with
// status, out_degree, vertex_total, edge_total and all_reached.
// The cfg_we / cfg_wdata port loads the initial vertex count, which reloads
// the graph; the user must write it only while the block is idle, as the
// block itself does not enforce this. A request is taken only while the
// sequencer is idle, so one item is worked on at a time. Add vertex goes
// through decode and done to the result register. Add and delete edge
// scan the adjacency list one slot a cycle through the single read port of
// the edge store; on a delete the slots after the match are shifted in the
// same pass. A connectivity check pops the search stack, skips a vertex
// already visited, reads the degree of a new one and then scans its edges
// one per cycle, pushing each unvisited target while the stack has room.
// Reset clears the vertex count, the edge count and all degrees at once
// through valid bits; no clearing pass is needed. A result waits in the output
// register while the receiver stalls, and a new item can be accepted then;
// the next result waits until that register frees up.
`default_nettype none

module directed_graph_reachability_table
    import dgrt_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int unsigned MAX_DEGREE   = MAX_DEGREE_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    dgrt_req_if.sink              req,
    dgrt_rsp_if.source            rsp
);

    localparam int VXW         = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int VCW         = $clog2(MAX_VERTICES + 1);
    localparam int DGW         = $clog2(MAX_DEGREE + 1);
    localparam int SLOTS       = MAX_VERTICES * MAX_DEGREE;
    localparam int SAW         = $clog2(SLOTS);
    localparam int ECW         = $clog2(SLOTS + 1);
    localparam int STACK_DEPTH = SLOTS + 1;
    localparam int STW         = $clog2(STACK_DEPTH);
    localparam int SPW         = $clog2(STACK_DEPTH + 1);
    localparam int CW0         = (VCW > VTX_W + 1) ? VCW : VTX_W + 1;
    localparam int CW          = (CW0 > CFG_W + 1) ? CW0 : CFG_W + 1;
    localparam int DXW         = DGW + 1;

    localparam logic [SAW-1:0] DEG_STRIDE = SAW'(MAX_DEGREE);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_DECODE = 11'b00000000010,
        S_FIND   = 11'b00000000100,
        S_SHIFT  = 11'b00000001000,
        S_DELFIN = 11'b00000010000,
        S_APPEND = 11'b00000100000,
        S_POP    = 11'b00001000000,
        S_VTX    = 11'b00010000000,
        S_VDEG   = 11'b00100000000,
        S_EDGE   = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    kind_t kind_reg, kind_next;
    logic [VTX_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [COST_W-1:0] cost_reg, cost_next;
    logic [DGW-1:0] deg_reg, deg_next, idx_reg, idx_next;
    logic [SAW-1:0] base_reg, base_next;
    logic [VCW-1:0] vc_reg, vc_next, reached_reg, reached_next;
    logic [ECW-1:0] ec_reg, ec_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [MAX_VERTICES-1:0] vis_reg, vis_next, deg_vld_reg, deg_vld_next;
    status_t res_status_reg, res_status_next;
    logic [DGW-1:0] res_deg_reg, res_deg_next;
    logic res_reach_reg, res_reach_next;
    logic out_valid_reg, out_valid_next;
    rsp_t out_data_reg, out_data_next;

    logic [DGW-1:0] deg_mem [MAX_VERTICES];
    logic [VXW-1:0] tgt_mem [SLOTS];
    logic [COST_W-1:0] cost_mem [SLOTS];
    logic [VXW-1:0] stack_mem [STACK_DEPTH];

    logic [DGW-1:0] deg_q;
    logic deg_vld_q;
    logic [VXW-1:0] tgt_q, stack_q;
    logic [COST_W-1:0] cost_q;

    logic [VXW-1:0] deg_raddr;
    logic deg_we;
    logic [DGW-1:0] deg_wdata;
    logic [SAW-1:0] edge_raddr, edge_waddr;
    logic tgt_we, cost_we;
    logic [VXW-1:0] tgt_wdata, stack_wdata;
    logic [COST_W-1:0] cost_wdata;
    logic stack_we;
    logic [STW-1:0] stack_raddr, stack_waddr;

    logic [DGW-1:0] deg_eff;
    logic [VXW-1:0] xi, yi;
    logic [SAW-1:0] base_calc;
    logic [DXW-1:0] idx_inc;
    logic more_slots;
    logic in_range;
    logic [SPW-1:0] sp_dec;

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    assign deg_eff    = deg_vld_q ? deg_q : '0;
    assign xi         = VXW'(x_reg);
    assign yi         = VXW'(y_reg);
    assign base_calc  = SAW'(xi) * DEG_STRIDE;
    assign idx_inc    = DXW'(idx_reg) + DXW'(1);
    assign more_slots = idx_inc < DXW'(deg_reg);
    assign in_range   = (CW'(x_reg) < CW'(vc_reg)) && (CW'(y_reg) < CW'(vc_reg));
    assign sp_dec     = sp_reg - SPW'(1);

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        cost_next       = cost_reg;
        deg_next        = deg_reg;
        idx_next        = idx_reg;
        base_next       = base_reg;
        vc_next         = vc_reg;
        reached_next    = reached_reg;
        ec_next         = ec_reg;
        sp_next         = sp_reg;
        vis_next        = vis_reg;
        deg_vld_next    = deg_vld_reg;
        res_status_next = res_status_reg;
        res_deg_next    = res_deg_reg;
        res_reach_next  = res_reach_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        deg_raddr   = VXW'(req.data.from_vertex);
        deg_we      = 1'b0;
        deg_wdata   = deg_reg;
        edge_raddr  = base_reg + SAW'(idx_reg);
        edge_waddr  = base_reg + SAW'(idx_reg);
        tgt_we      = 1'b0;
        cost_we     = 1'b0;
        tgt_wdata   = tgt_q;
        cost_wdata  = cost_q;
        stack_we    = 1'b0;
        stack_waddr = sp_reg[STW-1:0];
        stack_wdata = tgt_q;
        stack_raddr = sp_dec[STW-1:0];

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next  = req.data.kind;
                    x_next     = req.data.from_vertex;
                    y_next     = req.data.to_vertex;
                    cost_next  = req.data.edge_cost;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                res_status_next = STAT_OK;
                res_deg_next    = '0;
                res_reach_next  = 1'b0;
                state_next      = S_DONE;
                case (kind_reg)
                    KIND_ADD_EDGE, KIND_DEL_EDGE:
                    begin
                        if (!in_range)
                        begin
                            res_status_next = STAT_RANGE;
                        end
                        else
                        begin
                            deg_next   = deg_eff;
                            idx_next   = '0;
                            base_next  = base_calc;
                            edge_raddr = base_calc;
                            if (deg_eff != '0)
                            begin
                                state_next = S_FIND;
                            end
                            else if (kind_reg == KIND_ADD_EDGE)
                            begin
                                state_next = S_APPEND;
                            end
                            else
                            begin
                                res_status_next = STAT_NOT_FOUND;
                            end
                        end
                    end
                    KIND_ADD_VERTEX:
                    begin
                        if (vc_reg >= VCW'(MAX_VERTICES))
                        begin
                            res_status_next = STAT_TABLE_FULL;
                        end
                        else
                        begin
                            vc_next = vc_reg + VCW'(1);
                        end
                    end
                    KIND_CHECK:
                    begin
                        if (vc_reg == '0)
                        begin
                            res_reach_next = 1'b1;
                        end
                        else
                        begin
                            vis_next     = '0;
                            reached_next = '0;
                            stack_we     = 1'b1;
                            stack_waddr  = '0;
                            stack_wdata  = VXW'(vc_reg - VCW'(1));
                            sp_next      = SPW'(1);
                            state_next   = S_POP;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_FIND:
            begin
                if (tgt_q == yi)
                begin
                    if (kind_reg == KIND_ADD_EDGE)
                    begin
                        cost_we      = 1'b1;
                        cost_wdata   = cost_reg;
                        res_deg_next = deg_reg;
                        state_next   = S_DONE;
                    end
                    else if (more_slots)
                    begin
                        edge_raddr = base_reg + SAW'(idx_inc);
                        idx_next   = DGW'(idx_inc);
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_DELFIN;
                    end
                end
                else if (more_slots)
                begin
                    edge_raddr = base_reg + SAW'(idx_inc);
                    idx_next   = DGW'(idx_inc);
                end
                else if (kind_reg == KIND_ADD_EDGE)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    res_status_next = STAT_NOT_FOUND;
                    res_deg_next    = deg_reg;
                    state_next      = S_DONE;
                end
            end
            S_SHIFT:
            begin
                tgt_we     = 1'b1;
                cost_we    = 1'b1;
                edge_waddr = base_reg + SAW'(idx_reg) - SAW'(1);
                if (more_slots)
                begin
                    edge_raddr = base_reg + SAW'(idx_inc);
                    idx_next   = DGW'(idx_inc);
                end
                else
                begin
                    state_next = S_DELFIN;
                end
            end
            S_DELFIN:
            begin
                deg_we       = 1'b1;
                deg_wdata    = deg_reg - DGW'(1);
                ec_next      = ec_reg - ECW'(1);
                res_deg_next = deg_reg - DGW'(1);
                state_next   = S_DONE;
            end
            S_APPEND:
            begin
                if (deg_reg >= DGW'(MAX_DEGREE))
                begin
                    res_status_next = STAT_DEGREE_FULL;
                    res_deg_next    = deg_reg;
                end
                else
                begin
                    tgt_we       = 1'b1;
                    cost_we      = 1'b1;
                    edge_waddr   = base_reg + SAW'(deg_reg);
                    tgt_wdata    = yi;
                    cost_wdata   = cost_reg;
                    deg_we       = 1'b1;
                    deg_wdata    = deg_reg + DGW'(1);
                    ec_next      = ec_reg + ECW'(1);
                    res_deg_next = deg_reg + DGW'(1);
                end
                state_next = S_DONE;
            end
            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    res_reach_next = (reached_reg == vc_reg);
                    state_next     = S_DONE;
                end
                else
                begin
                    sp_next    = sp_dec;
                    state_next = S_VTX;
                end
            end
            S_VTX:
            begin
                deg_raddr = stack_q;
                if (vis_reg[stack_q])
                begin
                    state_next = S_POP;
                end
                else
                begin
                    vis_next[stack_q] = 1'b1;
                    reached_next      = reached_reg + VCW'(1);
                    base_next         = SAW'(stack_q) * DEG_STRIDE;
                    state_next        = S_VDEG;
                end
            end
            S_VDEG:
            begin
                deg_next   = deg_eff;
                idx_next   = '0;
                edge_raddr = base_reg;
                if (deg_eff == '0)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_EDGE;
                end
            end
            S_EDGE:
            begin
                if (!vis_reg[tgt_q] && (sp_reg < SPW'(STACK_DEPTH)))
                begin
                    stack_we = 1'b1;
                    sp_next  = sp_reg + SPW'(1);
                end
                if (more_slots)
                begin
                    edge_raddr = base_reg + SAW'(idx_inc);
                    idx_next   = DGW'(idx_inc);
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.status       = res_status_reg;
                    out_data_next.out_degree   = DEG_W'(res_deg_reg);
                    out_data_next.vertex_total = VTOT_W'(vc_reg);
                    out_data_next.edge_total   = ETOT_W'(ec_reg);
                    out_data_next.all_reached  = res_reach_reg;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (deg_we)
        begin
            deg_vld_next[xi] = 1'b1;
        end

        if (cfg_we)
        begin
            if (CW'(cfg_wdata) > CW'(MAX_VERTICES))
            begin
                vc_next = VCW'(MAX_VERTICES);
            end
            else
            begin
                vc_next = VCW'(cfg_wdata);
            end
            ec_next      = '0;
            deg_vld_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vc_reg        <= '0;
            ec_reg        <= '0;
            sp_reg        <= '0;
            vis_reg       <= '0;
            deg_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vc_reg        <= vc_next;
            ec_reg        <= ec_next;
            sp_reg        <= sp_next;
            vis_reg       <= vis_next;
            deg_vld_reg   <= deg_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        cost_reg       <= cost_next;
        deg_reg        <= deg_next;
        idx_reg        <= idx_next;
        base_reg       <= base_next;
        reached_reg    <= reached_next;
        res_status_reg <= res_status_next;
        res_deg_reg    <= res_deg_next;
        res_reach_reg  <= res_reach_next;
        out_data_reg   <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (deg_we)
        begin
            deg_mem[xi] <= deg_wdata;
        end
        deg_q     <= deg_mem[deg_raddr];
        deg_vld_q <= deg_vld_reg[deg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tgt_we)
        begin
            tgt_mem[edge_waddr] <= tgt_wdata;
        end
        tgt_q <= tgt_mem[edge_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cost_we)
        begin
            cost_mem[edge_waddr] <= cost_wdata;
        end
        cost_q <= cost_mem[edge_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        stack_q <= stack_mem[stack_raddr];
    end

    // The search never pushes more entries than there are edges plus one.
    assert property (@(posedge clk) disable iff (!rst_n) sp_reg <= SPW'(STACK_DEPTH))
        else $error("search stack pointer beyond stack depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ec_reg <= ECW'(SLOTS)) && (vc_reg <= VCW'(MAX_VERTICES)))
        else $error("edge or vertex count beyond table size");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.all_reached) |-> (rsp.data.out_degree == '0))
        else $error("check result carries a nonzero out-degree");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DELFIN) |=> (ec_reg == $past(ec_reg) - ECW'(1)))
        else $error("edge count not decremented on delete");

endmodule

`default_nettype wire

// ===== dv/graph_checker.sv =====
`timescale 1ns / 100ps

module graph_checker
    import dgrt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    dgrt_req_if.sink              req_mon,
    dgrt_rsp_if.sink              rsp_mon,
    output int                    fail_count,
    output int                    pending
);
    localparam int NV = MAX_VERTICES_DEF;
    localparam int ND = MAX_DEGREE_DEF;

    int unsigned vtx_count;
    int unsigned degree[NV];
    logic [VTX_W-1:0] target[NV][ND];
    logic [COST_W-1:0] cost[NV][ND];
    int unsigned edges;
    rsp_t expected_rsp[$];
    int mismatches;

    function automatic void load_graph(int unsigned init);
        vtx_count = (init > NV) ? NV : init;
        foreach (degree[i]) degree[i] = 0;
        edges = 0;
    endfunction

    function automatic int unsigned find_slot(int unsigned u, int unsigned v);
        for (int unsigned i = 0; i < degree[u]; i++)
            if (target[u][i] == v) return i;
        return ND;
    endfunction

    function automatic logic all_reachable();
        bit seen[NV];
        int unsigned stk[NV * ND + 1];
        int unsigned sp;
        int unsigned reached;
        int unsigned v;
        reached = 0;
        sp = 0;
        if (vtx_count == 0) return 1'b1;
        stk[sp] = vtx_count - 1;
        sp = sp + 1;
        while (sp > 0) begin
            sp = sp - 1;
            v = stk[sp];
            if (seen[v]) continue;
            seen[v] = 1;
            reached++;
            for (int unsigned i = 0; i < degree[v]; i++)
                if (!seen[target[v][i]] && sp < NV * ND + 1) begin
                    stk[sp] = target[v][i];
                    sp = sp + 1;
                end
        end
        return reached == vtx_count;
    endfunction

    function automatic rsp_t apply_request(req_t r);
        rsp_t res;
        int unsigned x, y, s;
        x = r.from_vertex;
        y = r.to_vertex;
        res = '0;
        res.status = STAT_OK;
        case (r.kind)
            KIND_ADD_EDGE, KIND_DEL_EDGE:
            begin
                if (x >= vtx_count || y >= vtx_count)
                begin
                    res.status = STAT_RANGE;
                end
                else
                begin
                    s = find_slot(x, y);
                    if (r.kind == KIND_ADD_EDGE)
                    begin
                        if (s < ND)
                            cost[x][s] = r.edge_cost;
                        else if (degree[x] >= ND)
                            res.status = STAT_DEGREE_FULL;
                        else
                        begin
                            target[x][degree[x]] = VTX_W'(y);
                            cost[x][degree[x]] = r.edge_cost;
                            degree[x]++;
                            edges++;
                        end
                    end
                    else if (s >= ND)
                    begin
                        res.status = STAT_NOT_FOUND;
                    end
                    else
                    begin
                        for (int unsigned i = s; i + 1 < degree[x]; i++)
                        begin
                            target[x][i] = target[x][i+1];
                            cost[x][i] = cost[x][i+1];
                        end
                        degree[x]--;
                        edges--;
                    end
                    res.out_degree = DEG_W'(degree[x]);
                end
            end
            KIND_ADD_VERTEX:
            begin
                if (vtx_count >= NV) res.status = STAT_TABLE_FULL;
                else vtx_count++;
            end
            default: res.all_reached = all_reachable();
        endcase
        res.vertex_total = VTOT_W'(vtx_count);
        res.edge_total = ETOT_W'(edges);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t got, want;
        if (!rst_n)
        begin
            load_graph(0);
            expected_rsp.delete();
            fail_count <= 0;
            pending <= 0;
            mismatches = 0;
        end
        else
        begin
            if (cfg_we) load_graph(cfg_wdata);
            if (req_mon.valid && req_mon.ready)
                expected_rsp = {expected_rsp, apply_request(req_mon.data)};
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                got = rsp_mon.data;
                if (expected_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result item %p", got);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (got.status !== want.status || got.out_degree !== want.out_degree
                        || got.vertex_total !== want.vertex_total
                        || got.edge_total !== want.edge_total
                        || got.all_reached !== want.all_reached)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %p, got %p", want, got);
                    end
                end
                fail_count <= mismatches;
            end
            pending <= expected_rsp.size();
        end
    end
endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import dgrt_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    int fail_count;
    int pending;
    int cycles;

    dgrt_req_if req ();
    dgrt_rsp_if rsp ();

    directed_graph_reachability_table dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .req(req.sink), .rsp(rsp.source)
    );

    graph_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .req_mon(req.sink), .rsp_mon(rsp.sink),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 0;
    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    function automatic int unsigned gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("FAIL directed_graph_reachability_table");
            $finish;
        end
    end

    int unsigned ready_hold;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 0;
            ready_hold = 0;
        end
        else if (ready_hold > 0)
        begin
            ready_hold--;
            rsp.ready <= 0;
        end
        else
        begin
            rsp.ready <= 1;
            if (rsp.valid && rsp.ready) ready_hold = gap_len();
        end
    end

    task automatic send(kind_t k, int unsigned f, int unsigned t, logic [31:0] c);
        int unsigned g;
        g = gap_len();
        repeat (g) @(posedge clk);
        req.valid <= 1;
        req.data.kind <= k;
        req.data.from_vertex <= VTX_W'(f);
        req.data.to_vertex <= VTX_W'(t);
        req.data.edge_cost <= c;
        do @(posedge clk); while (!req.ready);
        req.valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain_and_config(int unsigned v);
        while (pending != 0) @(posedge clk);
        repeat (1500) @(posedge clk);
        cfg_we <= 1;
        cfg_wdata <= CFG_W'(v);
        @(posedge clk);
        cfg_we <= 0;
    endtask

    task automatic random_phase(int unsigned n, int unsigned vmax);
        int unsigned r;
        kind_t k;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            k = r < 55 ? KIND_ADD_EDGE : r < 75 ? KIND_DEL_EDGE
                : r < 85 ? KIND_ADD_VERTEX : KIND_CHECK;
            if ($urandom_range(0, 9) == 0)
                send(k, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
            else
                send(k, $urandom_range(0, vmax), $urandom_range(0, vmax), $urandom);
            if (i == n / 2) while (pending != 0) @(posedge clk);
        end
    endtask

    initial
    begin
        cycles = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        req.valid = 0;
        req.data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send(KIND_CHECK, 0, 0, 0);
        send(KIND_ADD_EDGE, 0, 0, 1);
        send(KIND_ADD_VERTEX, 0, 0, 0);
        send(KIND_ADD_VERTEX, 0, 0, 0);
        send(KIND_CHECK, 0, 0, 0);
        send(KIND_ADD_EDGE, 1, 0, 32'h7fffffff);
        send(KIND_ADD_EDGE, 1, 0, 32'h80000000);
        send(KIND_CHECK, 0, 0, 0);
        send(KIND_DEL_EDGE, 0, 1, 0);
        send(KIND_DEL_EDGE, 1, 0, 0);

        drain_and_config(7'd127);
        send(KIND_ADD_VERTEX, 0, 0, 0);
        for (int i = 0; i < 17; i++)
            send(KIND_ADD_EDGE, 63, i, 32'hffffffff);
        send(KIND_DEL_EDGE, 63, 5, 0);
        send(KIND_ADD_EDGE, 63, 63, 0);
        send(KIND_CHECK, 0, 0, 0);

        drain_and_config(7'd8);
        random_phase(120, 9);
        drain_and_config(7'd64);
        random_phase(90, 63);
        drain_and_config(7'd3);
        random_phase(40, 4);

        while (pending != 0) @(posedge clk);
        repeat (1500) @(posedge clk);
        if (fail_count == 0)
            $display("PASS directed_graph_reachability_table");
        else
            $display("FAIL directed_graph_reachability_table");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/dgrt_pkg.sv
rtl/core/dgrt_req_if.sv
rtl/core/dgrt_rsp_if.sv
rtl/core/directed_graph_reachability_table.sv
dv/graph_checker.sv
dv/testbench.sv
